// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SWBM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SWBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/swbm_pkg.sv =====
`default_nettype none

package swbm_pkg;

    localparam int unsigned WORDS      = 65536;
    localparam int unsigned ADDR_W     = $clog2(WORDS);
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned SEG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_READ_WORD  = 2'd0,
        OP_WRITE_WORD = 2'd1,
        OP_READ_BYTE  = 2'd2,
        OP_WRITE_BYTE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_BOUNDS = 2'd1,
        ST_PROTECTED     = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_START  = 4'd0,
        REG_CODE_END    = 4'd1,
        REG_DATA_START  = 4'd2,
        REG_DATA_END    = 4'd3,
        REG_STACK_START = 4'd4,
        REG_STACK_END   = 4'd5,
        REG_CODE_RO     = 4'd6,
        REG_STATS_EN    = 4'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_RESULT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load_item;
        logic access;
        logic finish;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/segmented_word_byte_memory.sv =====
// Word-addressed 32-bit memory with byte access, segment protection and access statistics.
// Input channel: in_valid/in_ready carry one beat of operation, address and write_data.
// Output channel: out_valid/out_ready carry one beat of read_data, status and the
// seven statistics counters as they stand after that access.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock edge;
// indexes beyond the last register are ignored. Write only while the block is idle.
// Each accepted input beat passes through the states ACCESS, RESULT and EMIT: ACCESS does the
// memory read and segment checks with word writes and counters, RESULT uses the registered
// read data (byte merge, byte extract, stack peak) and EMIT loads the output register.
// The block returns to idle only after EMIT, so no new beat is accepted before the last
// one is through; the registered memory read and the byte read-modify-write make the
// block work through these states.
// After reset the block clears all 65536 memory words one word per cycle,
// with in_ready low; configuration writes are taken during that pass.
// A result waiting on a stalled receiver stays in the output register; the next beat
// may be accepted and processed, but its result is held until the output is taken.
`default_nettype none

module segmented_word_byte_memory (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [swbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [swbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [1:0]                       operation,
    input  wire  [swbm_pkg::DATA_W-1:0]      address,
    input  wire  [swbm_pkg::DATA_W-1:0]      write_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [swbm_pkg::DATA_W-1:0]      read_data,
    output logic [1:0]                       status,
    output logic [swbm_pkg::DATA_W-1:0]      total_accesses,
    output logic [swbm_pkg::DATA_W-1:0]      total_reads,
    output logic [swbm_pkg::DATA_W-1:0]      total_writes,
    output logic [swbm_pkg::DATA_W-1:0]      code_hits,
    output logic [swbm_pkg::DATA_W-1:0]      data_hits,
    output logic [swbm_pkg::DATA_W-1:0]      stack_hits,
    output logic [swbm_pkg::DATA_W-1:0]      stack_peak
);
    import swbm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    swbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    swbm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .address        (address),
        .write_data     (write_data),
        .cmd            (cmd),
        .stat           (stat),
        .read_data      (read_data),
        .status         (status),
        .total_accesses (total_accesses),
        .total_reads    (total_reads),
        .total_writes   (total_writes),
        .code_hits      (code_hits),
        .data_hits      (data_hits),
        .stack_hits     (stack_hits),
        .stack_peak     (stack_peak)
    );

endmodule

`default_nettype wire

// ===== rtl/swbm_ctrl.sv =====
`default_nettype none

module swbm_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    output swbm_pkg::ctrl_cmd_t    cmd,
    input  swbm_pkg::dp_status_t   stat
);
    import swbm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        out_valid_next = cmd.emit | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/swbm_datapath.sv =====
`default_nettype none

module swbm_datapath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [swbm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [swbm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire  [1:0]                           operation,
    input  wire  [swbm_pkg::DATA_W-1:0]          address,
    input  wire  [swbm_pkg::DATA_W-1:0]          write_data,
    input  swbm_pkg::ctrl_cmd_t                  cmd,
    output swbm_pkg::dp_status_t                 stat,
    output logic [swbm_pkg::DATA_W-1:0]          read_data,
    output logic [1:0]                           status,
    output logic [swbm_pkg::DATA_W-1:0]          total_accesses,
    output logic [swbm_pkg::DATA_W-1:0]          total_reads,
    output logic [swbm_pkg::DATA_W-1:0]          total_writes,
    output logic [swbm_pkg::DATA_W-1:0]          code_hits,
    output logic [swbm_pkg::DATA_W-1:0]          data_hits,
    output logic [swbm_pkg::DATA_W-1:0]          stack_hits,
    output logic [swbm_pkg::DATA_W-1:0]          stack_peak
);
    import swbm_pkg::*;

    logic [SEG_W-1:0] code_start_reg;
    logic [SEG_W-1:0] code_end_reg;
    logic [SEG_W-1:0] data_start_reg;
    logic [SEG_W-1:0] data_end_reg;
    logic [SEG_W-1:0] stack_start_reg;
    logic [SEG_W-1:0] stack_end_reg;
    logic             code_ro_reg;
    logic             stats_en_reg;

    op_t               op_reg;
    logic [DATA_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] result_reg;

    logic [DATA_W-1:0] access_cnt_reg;
    logic [DATA_W-1:0] read_cnt_reg;
    logic [DATA_W-1:0] write_cnt_reg;
    logic [DATA_W-1:0] code_cnt_reg;
    logic [DATA_W-1:0] data_cnt_reg;
    logic [DATA_W-1:0] stack_cnt_reg;
    logic [DATA_W-1:0] peak_cnt_reg;

    logic [ADDR_W-1:0] clr_idx_reg;

    logic [DATA_W-1:0] out_data_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_access_reg;
    logic [DATA_W-1:0] out_read_reg;
    logic [DATA_W-1:0] out_write_reg;
    logic [DATA_W-1:0] out_code_reg;
    logic [DATA_W-1:0] out_data_hits_reg;
    logic [DATA_W-1:0] out_stack_reg;
    logic [DATA_W-1:0] out_peak_reg;

    logic [DATA_W-1:0] mem [WORDS];

    logic [DATA_W-1:0] waddr;
    logic [ADDR_W-1:0] widx;
    logic              oob;
    logic              in_code;
    logic              in_data;
    logic              in_stack;
    status_t           status_now;
    logic              count_now;
    logic [4:0]        shift;
    logic [DATA_W-1:0] lane_mask;
    logic [DATA_W-1:0] merged;
    logic [7:0]        byte_rd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    always_comb
    begin
        waddr    = op_reg[1] ? {2'b00, addr_reg[DATA_W-1:2]} : addr_reg;
        widx     = waddr[ADDR_W-1:0];
        oob      = (waddr >= DATA_W'(WORDS));
        in_code  = (waddr >= DATA_W'(code_start_reg)) && (waddr <= DATA_W'(code_end_reg));
        in_data  = (waddr >= DATA_W'(data_start_reg)) && (waddr <= DATA_W'(data_end_reg));
        in_stack = (waddr >= DATA_W'(stack_start_reg)) && (waddr <= DATA_W'(stack_end_reg));
        if (oob)
        begin
            status_now = ST_OUT_OF_BOUNDS;
        end
        else if (op_reg[0] && code_ro_reg && in_code)
        begin
            status_now = ST_PROTECTED;
        end
        else
        begin
            status_now = ST_OK;
        end
        count_now = cmd.access && (status_now == ST_OK) && !op_reg[1] && stats_en_reg;

        shift     = {~addr_reg[1:0], 3'b000};
        lane_mask = 32'h0000_00FF << shift;
        merged    = (rd_data_reg & ~lane_mask) | ({24'h000000, wdata_reg[7:0]} << shift);
        byte_rd   = 8'(rd_data_reg >> shift);

        mem_we    = 1'b0;
        mem_waddr = widx;
        mem_wdata = wdata_reg;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (cmd.access && (status_now == ST_OK) && (op_reg == OP_WRITE_WORD))
        begin
            mem_we = 1'b1;
        end
        else if (cmd.finish && (status_reg == ST_OK) && (op_reg == OP_WRITE_BYTE))
        begin
            mem_we    = 1'b1;
            mem_wdata = merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[widx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_start_reg  <= 16'd0;
            code_end_reg    <= 16'd16383;
            data_start_reg  <= 16'd16384;
            data_end_reg    <= 16'd49151;
            stack_start_reg <= 16'd49152;
            stack_end_reg   <= 16'd65535;
            code_ro_reg     <= 1'b1;
            stats_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE_START:  code_start_reg  <= cfg_data;
                REG_CODE_END:    code_end_reg    <= cfg_data;
                REG_DATA_START:  data_start_reg  <= cfg_data;
                REG_DATA_END:    data_end_reg    <= cfg_data;
                REG_STACK_START: stack_start_reg <= cfg_data;
                REG_STACK_END:   stack_end_reg   <= cfg_data;
                REG_CODE_RO:     code_ro_reg     <= cfg_data[0];
                REG_STATS_EN:    stats_en_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            access_cnt_reg <= '0;
            read_cnt_reg   <= '0;
            write_cnt_reg  <= '0;
            code_cnt_reg   <= '0;
            data_cnt_reg   <= '0;
            stack_cnt_reg  <= '0;
            peak_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (count_now)
            begin
                access_cnt_reg <= access_cnt_reg + 1'b1;
                if (op_reg[0])
                begin
                    write_cnt_reg <= write_cnt_reg + 1'b1;
                end
                else
                begin
                    read_cnt_reg <= read_cnt_reg + 1'b1;
                end
                if (in_code)
                begin
                    code_cnt_reg <= code_cnt_reg + 1'b1;
                end
                else if (in_data)
                begin
                    data_cnt_reg <= data_cnt_reg + 1'b1;
                end
                else if (in_stack)
                begin
                    stack_cnt_reg <= stack_cnt_reg + 1'b1;
                end
            end
            // The peak only falls behind the stack count just after an increment.
            if (cmd.finish && (stack_cnt_reg > peak_cnt_reg))
            begin
                peak_cnt_reg <= stack_cnt_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= op_t'(operation);
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (cmd.access)
        begin
            status_reg <= status_now;
        end
        if (cmd.finish)
        begin
            if (status_reg != ST_OK)
            begin
                result_reg <= '0;
            end
            else if (op_reg == OP_READ_WORD)
            begin
                result_reg <= rd_data_reg;
            end
            else if (op_reg == OP_READ_BYTE)
            begin
                result_reg <= {24'h000000, byte_rd};
            end
            else
            begin
                result_reg <= '0;
            end
        end
        if (cmd.emit)
        begin
            out_data_reg      <= result_reg;
            out_status_reg    <= status_reg;
            out_access_reg    <= access_cnt_reg;
            out_read_reg      <= read_cnt_reg;
            out_write_reg     <= write_cnt_reg;
            out_code_reg      <= code_cnt_reg;
            out_data_hits_reg <= data_cnt_reg;
            out_stack_reg     <= stack_cnt_reg;
            out_peak_reg      <= peak_cnt_reg;
        end
    end

    assign stat.clear_last = (clr_idx_reg == ADDR_W'(WORDS - 1));

    assign read_data      = out_data_reg;
    assign status         = out_status_reg;
    assign total_accesses = out_access_reg;
    assign total_reads    = out_read_reg;
    assign total_writes   = out_write_reg;
    assign code_hits      = out_code_reg;
    assign data_hits      = out_data_hits_reg;
    assign stack_hits     = out_stack_reg;
    assign stack_peak     = out_peak_reg;

endmodule

`default_nettype wire

// ===== rtl/swbm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module swbm_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire  [swbm_pkg::DATA_W-1:0]      read_data,
    input wire  [1:0]                       status
);
    import swbm_pkg::*;

    `SWBM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SWBM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `SWBM_ASSERT_NOW(a_status_in_range, out_valid, status <= ST_PROTECTED)
    `SWBM_ASSERT_NOW(a_error_reads_zero, out_valid && (status != ST_OK), read_data == '0)

endmodule

bind segmented_word_byte_memory swbm_checker u_swbm_checker (.*);

`default_nettype wire

// ===== sim/segmented_word_byte_memory_tb.sv =====
`timescale 1ns / 1ps

module segmented_word_byte_memory_tb;

    import swbm_pkg::*;

    localparam int unsigned HOT_COUNT       = 16;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned FINAL_CYCLES    = 20;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned MAX_REPORTS     = 40;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = 4'd8;
    localparam logic [CFG_IDX_W-1:0] MID_UNUSED_REG   = 4'd11;
    localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG  = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        status_t           status;
        logic [DATA_W-1:0] accesses;
        logic [DATA_W-1:0] reads;
        logic [DATA_W-1:0] writes;
        logic [DATA_W-1:0] code_hits;
        logic [DATA_W-1:0] data_hits;
        logic [DATA_W-1:0] stack_hits;
        logic [DATA_W-1:0] stack_peak;
    } access_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation = '0;
    logic [DATA_W-1:0]     address = '0;
    logic [DATA_W-1:0]     write_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic [1:0]            status;
    logic [DATA_W-1:0]     total_accesses;
    logic [DATA_W-1:0]     total_reads;
    logic [DATA_W-1:0]     total_writes;
    logic [DATA_W-1:0]     code_hits;
    logic [DATA_W-1:0]     data_hits;
    logic [DATA_W-1:0]     stack_hits;
    logic [DATA_W-1:0]     stack_peak;

    segmented_word_byte_memory dut (.*);

    // Mirror of the block's registers, memory and statistics.
    logic [SEG_W-1:0] code_lo = 16'd0;
    logic [SEG_W-1:0] code_hi = 16'd16383;
    logic [SEG_W-1:0] data_lo = 16'd16384;
    logic [SEG_W-1:0] data_hi = 16'd49151;
    logic [SEG_W-1:0] stack_lo = 16'd49152;
    logic [SEG_W-1:0] stack_hi = 16'd65535;
    logic             code_guard = 1'b1;
    logic             stats_on = 1'b0;

    bit [DATA_W-1:0] mem_image [0:WORDS-1];
    bit [DATA_W-1:0] n_access, n_read, n_write, n_code, n_data, n_stack, n_peak;

    access_result_t  access_results_due [$];
    logic [DATA_W-1:0] hot_words [HOT_COUNT];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic bit in_segment(input logic [DATA_W-1:0] waddr,
                                      input logic [SEG_W-1:0] lo,
                                      input logic [SEG_W-1:0] hi);
        return (waddr >= {16'd0, lo}) && (waddr <= {16'd0, hi});
    endfunction

    function automatic void tally_word_access(input logic [DATA_W-1:0] waddr,
                                              input bit is_write);
        if (!stats_on)
            return;
        n_access += 1;
        if (is_write)
            n_write += 1;
        else
            n_read += 1;
        if (in_segment(waddr, code_lo, code_hi))
            n_code += 1;
        else if (in_segment(waddr, data_lo, data_hi))
            n_data += 1;
        else if (in_segment(waddr, stack_lo, stack_hi))
        begin
            n_stack += 1;
            if (n_stack > n_peak)
                n_peak = n_stack;
        end
    endfunction

    function automatic access_result_t predict_access(input op_t op,
                                                      input logic [DATA_W-1:0] addr,
                                                      input logic [DATA_W-1:0] wdata);
        access_result_t   r;
        logic [DATA_W-1:0] waddr;
        int unsigned      shift;
        logic [DATA_W-1:0] lane_mask;
        bit               byte_op;
        bit               write_op;

        r = '0;
        byte_op  = (op == OP_READ_BYTE) || (op == OP_WRITE_BYTE);
        write_op = (op == OP_WRITE_WORD) || (op == OP_WRITE_BYTE);
        waddr = byte_op ? (addr >> 2) : addr;
        shift = 24 - 8 * addr[1:0];
        r.status = ST_OK;
        if (waddr >= WORDS)
            r.status = ST_OUT_OF_BOUNDS;
        else if (write_op && code_guard && in_segment(waddr, code_lo, code_hi))
            r.status = ST_PROTECTED;
        else
        begin
            case (op)
                OP_READ_WORD:
                begin
                    tally_word_access(waddr, 1'b0);
                    r.read_data = mem_image[waddr[ADDR_W-1:0]];
                end
                OP_WRITE_WORD:
                begin
                    tally_word_access(waddr, 1'b1);
                    mem_image[waddr[ADDR_W-1:0]] = wdata;
                end
                OP_READ_BYTE:
                begin
                    r.read_data = (mem_image[waddr[ADDR_W-1:0]] >> shift) & 32'hFF;
                end
                default:
                begin
                    lane_mask = 32'hFF << shift;
                    mem_image[waddr[ADDR_W-1:0]] =
                        (mem_image[waddr[ADDR_W-1:0]] & ~lane_mask) |
                        ((wdata & 32'hFF) << shift);
                end
            endcase
        end
        r.accesses   = n_access;
        r.reads      = n_read;
        r.writes     = n_write;
        r.code_hits  = n_code;
        r.data_hits  = n_data;
        r.stack_hits = n_stack;
        r.stack_peak = n_peak;
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s expected %h, got %h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        access_result_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (access_results_due.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result beat with none expected, got read_data %h status %0d",
                             $time, read_data, status);
            end
            else
            begin
                due = access_results_due.pop_front();
                compare_field("read_data", due.read_data, read_data);
                compare_field("status", {30'd0, due.status}, {30'd0, status});
                compare_field("total_accesses", due.accesses, total_accesses);
                compare_field("total_reads", due.reads, total_reads);
                compare_field("total_writes", due.writes, total_writes);
                compare_field("code_hits", due.code_hits, code_hits);
                compare_field("data_hits", due.data_hits, data_hits);
                compare_field("stack_hits", due.stack_hits, stack_hits);
                compare_field("stack_peak", due.stack_peak, stack_peak);
            end
        end
    end

    task automatic send_access(input op_t op, input logic [DATA_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        address    <= addr;
        write_data <= wdata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        access_results_due.push_back(predict_access(op, addr, wdata));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (access_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_CODE_START:  code_lo = value;
            REG_CODE_END:    code_hi = value;
            REG_DATA_START:  data_lo = value;
            REG_DATA_END:    data_hi = value;
            REG_STACK_START: stack_lo = value;
            REG_STACK_END:   stack_hi = value;
            REG_CODE_RO:     code_guard = value[0];
            REG_STATS_EN:    stats_on = value[0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    function automatic void build_hot_words();
        hot_words[0] = DATA_W'(code_lo);
        hot_words[1] = DATA_W'(code_hi);
        hot_words[2] = DATA_W'(data_lo);
        hot_words[3] = DATA_W'(data_hi);
        hot_words[4] = DATA_W'(stack_lo);
        hot_words[5] = DATA_W'(stack_hi);
        hot_words[6] = '0;
        hot_words[7] = DATA_W'(WORDS - 1);
        for (int i = 8; i < HOT_COUNT; i++)
            hot_words[i] = $urandom_range(WORDS - 1);
    endfunction

    // Flag registers get random upper bits, which the block must mask off.
    task automatic write_layout(input logic [SEG_W-1:0] cs, input logic [SEG_W-1:0] ce,
                                input logic [SEG_W-1:0] ds, input logic [SEG_W-1:0] de,
                                input logic [SEG_W-1:0] ss, input logic [SEG_W-1:0] se,
                                input logic ro, input logic st);
        write_reg(REG_CODE_START, cs);
        write_reg(REG_CODE_END, ce);
        write_reg(REG_DATA_START, ds);
        write_reg(REG_DATA_END, de);
        write_reg(REG_STACK_START, ss);
        write_reg(REG_STACK_END, se);
        write_reg(REG_CODE_RO, CFG_DATA_W'(($urandom_range(65535) & 32'hFFFE) | ro));
        write_reg(REG_STATS_EN, CFG_DATA_W'(($urandom_range(65535) & 32'hFFFE) | st));
        cfg_we <= 1'b0;
        build_hot_words();
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    function automatic logic [DATA_W-1:0] pick_address(input op_t op);
        logic [DATA_W-1:0] w;
        int unsigned       roll;
        roll = $urandom_range(99);
        if (roll >= 95)
            return $urandom;
        if (roll < 70)
            w = hot_words[$urandom_range(HOT_COUNT - 1)];
        else if (roll < 90)
            w = $urandom_range(WORDS - 1);
        else
            w = WORDS + $urandom_range(3);
        if (op == OP_READ_BYTE || op == OP_WRITE_BYTE)
            return (w << 2) | $urandom_range(3);
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic run_random_beats(input int unsigned count);
        op_t op;
        for (int unsigned i = 0; i < count; i++)
        begin
            op = op_t'($urandom_range(3));
            send_access(op, pick_address(op), pick_data());
        end
    endtask

    task automatic random_layout();
        logic [SEG_W-1:0] lo [3];
        logic [SEG_W-1:0] hi [3];
        for (int i = 0; i < 3; i++)
        begin
            hi[i] = SEG_W'($urandom_range(65535));
            lo[i] = ($urandom_range(4) == 0) ? SEG_W'($urandom_range(65535)) :
                                               SEG_W'($urandom_range(hi[i]));
        end
        write_layout(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                     1'($urandom_range(1)), $urandom_range(3) != 0);
    endtask

    task automatic test_directed_corners();
        logic [DATA_W-1:0] lane_base;
        lane_base = 32'd16385 << 2;
        write_layout(16'd0, 16'd16383, 16'd16384, 16'd49151, 16'd49152, 16'd65535,
                     1'b1, 1'b1);
        set_idling(0, 0);
        send_access(OP_WRITE_WORD, 32'd0, 32'hFFFFFFFF);
        send_access(OP_READ_WORD, 32'd0, 32'd0);
        send_access(OP_WRITE_WORD, 32'd16383, 32'h12345678);
        send_access(OP_WRITE_WORD, 32'd16384, 32'hFFFFFFFF);
        send_access(OP_READ_WORD, 32'd16384, 32'd0);
        send_access(OP_WRITE_WORD, 32'd49151, 32'd0);
        send_access(OP_WRITE_WORD, 32'd49152, 32'hA5A55A5A);
        send_access(OP_READ_WORD, 32'd49152, 32'd0);
        send_access(OP_WRITE_WORD, 32'd65535, 32'h5A5AA5A5);
        send_access(OP_READ_WORD, 32'd65535, 32'd0);
        send_access(OP_READ_WORD, 32'd65536, 32'd0);
        send_access(OP_WRITE_WORD, 32'hFFFFFFFF, 32'h0BADF00D);
        send_access(OP_WRITE_BYTE, lane_base, 32'hFFFFFF12);
        send_access(OP_WRITE_BYTE, lane_base + 1, 32'h00000034);
        send_access(OP_WRITE_BYTE, lane_base + 2, 32'hABCDEF56);
        send_access(OP_WRITE_BYTE, lane_base + 3, 32'h000000AB);
        send_access(OP_READ_WORD, 32'd16385, 32'd0);
        send_access(OP_READ_BYTE, lane_base, 32'd0);
        send_access(OP_READ_BYTE, lane_base + 3, 32'd0);
        send_access(OP_WRITE_BYTE, 32'd0, 32'h000000FF);
        send_access(OP_READ_BYTE, 32'd2, 32'd0);
        send_access(OP_WRITE_BYTE, 32'd262143, 32'hFFFFFFFF);
        send_access(OP_READ_BYTE, 32'd262143, 32'd0);
        send_access(OP_READ_WORD, 32'd65535, 32'd0);
        send_access(OP_READ_BYTE, 32'd262144, 32'd0);
        send_access(OP_WRITE_BYTE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_all_results();
    endtask

    task automatic test_overlapping_segments();
        write_layout(16'd100, 16'd2000, 16'd1000, 16'd3000, 16'd2500, 16'd65535,
                     1'b0, 1'b1);
        set_idling(87, 0);
        run_random_beats(100);
        wait_all_results();
    endtask

    task automatic test_empty_segments();
        write_layout(16'd5000, 16'd10, 16'd40000, 16'd39999, 16'd65535, 16'd65535,
                     1'b1, 1'b1);
        set_idling(0, 87);
        run_random_beats(100);
        wait_all_results();
    endtask

    task automatic test_extreme_registers();
        write_layout(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        set_idling(6, 6);
        run_random_beats(40);
        wait_all_results();
        write_layout(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     1'b1, 1'b1);
        set_idling(0, 0);
        run_random_beats(40);
        wait_all_results();
        write_layout(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 1'b1);
        set_idling(87, 0);
        run_random_beats(40);
        wait_all_results();
    endtask

    task automatic test_unused_register_index();
        write_layout(16'd0, 16'd999, 16'd1000, 16'd1999, 16'd2000, 16'd2999, 1'b1, 1'b1);
        write_reg(FIRST_UNUSED_REG, CFG_DATA_W'($urandom_range(65535)));
        write_reg(LAST_UNUSED_REG, 16'hFFFF);
        write_reg(MID_UNUSED_REG, 16'h0000);
        cfg_we <= 1'b0;
        set_idling(0, 87);
        run_random_beats(20);
        wait_all_results();
    endtask

    task automatic test_random_layouts();
        for (int i = 0; i < 4; i++)
        begin
            random_layout();
            case (i)
                0: set_idling(0, 0);
                1: set_idling(87, 0);
                2: set_idling(0, 87);
                default: set_idling(6, 6);
            endcase
            run_random_beats(60);
            wait_all_results();
        end
    endtask

    // The receiver holds off while the sender keeps offering beats, so the block
    // fills up and must stall its input.
    task automatic test_output_hold_off();
        write_layout(16'd0, 16'd16383, 16'd16384, 16'd49151, 16'd49152, 16'd65535,
                     1'b0, 1'b1);
        set_idling(0, 0);
        hold_left <= HOLD_OFF_CYCLES;
        run_random_beats(30);
        wait_all_results();
    endtask

    task automatic test_sender_pause();
        set_idling(0, 6);
        run_random_beats(10);
        wait_all_results();
        run_random_beats(10);
        wait_all_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_overlapping_segments();
        test_empty_segments();
        test_extreme_registers();
        test_unused_register_index();
        test_random_layouts();
        test_output_hold_off();
        test_sender_pause();
        repeat (FINAL_CYCLES) @(posedge clk);
        if (failures == 0 && access_results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
